>>> sv/iecr_pkg.sv
// Package with the shared types, constants and checksum helper of the ICMP echo checker.
`default_nettype none

package iecr_pkg;

    // ICMP header constants.
    localparam logic [7:0] ICMP_TYPE_ECHO_REQ = 8'd8;
    localparam logic [7:0] ICMP_CODE_ECHO     = 8'd0;
    localparam logic [3:0] HEADER_BYTES       = 4'd8;

    // Byte positions inside the header that need special handling.
    localparam logic [3:0] POS_TYPE    = 4'd0;
    localparam logic [3:0] POS_CODE    = 4'd1;
    localparam logic [3:0] POS_CSUM_HI = 4'd2;
    localparam logic [3:0] POS_CSUM_LO = 4'd3;

    // Value of a correct ones-complement sum over a whole message.
    localparam logic [15:0] SUM_GOOD = 16'hFFFF;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_REPLY     = 3'd0,
        ST_SHORT     = 3'd1,
        ST_CSUM_ERR  = 3'd2,
        ST_BAD_TYPE  = 3'd3,
        ST_BAD_CODE  = 3'd4
    } t_status;

    // One input byte with its end-of-message mark.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    // One result item.
    typedef struct packed {
        t_status     status;
        logic [15:0] reply_checksum;
    } t_result;

    // Ones-complement 16-bit add with end-around carry.
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

`default_nettype wire

>>> sv/iecr_in_if.sv
// Interface for the byte input channel of the ICMP echo checker.
`default_nettype none

interface iecr_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);

endinterface

`default_nettype wire

>>> sv/iecr_out_if.sv
// Interface for the result channel of the ICMP echo checker.
`default_nettype none

interface iecr_out_if;

    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] reply_checksum;

    modport source (output valid, output status, output reply_checksum, input ready);
    modport sink   (input valid, input status, input reply_checksum, output ready);

endinterface

`default_nettype wire

>>> sv/icmp_echo_check_and_reply_core.sv
// Top level of the ICMP echo checker and reply checksum generator.
//
// Usage: an ICMP message enters on i_in_chan one byte per transfer, in network
// order, with last_byte set on its final byte. Bytes are paired into 16-bit
// words and added into two ones-complement running sums, one over the message
// as received and one with the type set to echo reply and the checksum field
// taken as zero. The final byte produces one transfer on o_out_chan with the
// status and, for a good echo request, the checksum for the reply header.
// Other bytes produce no result.
// Throughput: one byte per cycle while no final byte waits for a busy result
// slot, set by the accumulate step between the input and result registers.
// A final byte is held in the input register and its result is then captured
// in the result register, from which the receiver takes it.
// When the receiver stalls, the result waits in the output register while
// further bytes keep flowing; only a second final byte waits in the input
// register, and then ready on i_in_chan drops until the result is taken.
// Reset (synchronous, active low) empties both registers and clears the sums,
// the byte count and the captured header bytes. State also returns to these
// values after every final byte, so messages follow each other directly.
`default_nettype none

module icmp_echo_check_and_reply_core (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    iecr_in_if.sink      i_in_chan,
    iecr_out_if.source   o_out_chan
);

    iecr_pkg::t_in_item in_item;
    logic               in_valid;
    logic               out_free;
    logic               take;
    iecr_pkg::t_result  acc_result;

    logic               r_out_valid;
    iecr_pkg::t_result  r_out_result;

    // A held byte moves on unless it is a final byte and the result slot is busy.
    assign out_free = !r_out_valid || o_out_chan.ready;
    assign take     = in_valid && (!in_item.last_byte || out_free);

    iecr_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_chan (i_in_chan),
        .i_take    (take),
        .o_item    (in_item),
        .o_valid   (in_valid)
    );

    iecr_accum u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (take),
        .i_item   (in_item),
        .o_result (acc_result)
    );

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take && in_item.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (o_out_chan.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (take && in_item.last_byte) begin
            r_out_result <= acc_result;
        end
    end

    assign o_out_chan.valid          = r_out_valid;
    assign o_out_chan.status         = r_out_result.status;
    assign o_out_chan.reply_checksum = r_out_result.reply_checksum;

    // A consumed final byte always lands in the result register.
    a_final_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && in_item.last_byte) |=> r_out_valid)
        else $error("final byte did not produce a result");

    // The reply checksum is only nonzero on an echo reply result.
    a_chk_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_result.status != iecr_pkg::ST_REPLY)
            |-> (r_out_result.reply_checksum == 16'd0))
        else $error("reply checksum set on a failing message");

    // A byte that is not consumed stays in the input register.
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_valid && !take) |=> in_valid)
        else $error("input byte lost while stalled");

    // A blocked result is never overwritten by a new one.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out_chan.ready) |-> !(take && in_item.last_byte))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

>>> sv/iecr_in_reg.sv
// Input register that captures one byte transfer and holds it until it is consumed.
`default_nettype none

module iecr_in_reg (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    iecr_in_if.sink              i_in_chan,
    input  wire logic            i_take,
    output iecr_pkg::t_in_item   o_item,
    output logic                 o_valid
);

    logic               r_valid;
    iecr_pkg::t_in_item r_item;

    // The register takes a new transfer when empty or when its item leaves this cycle.
    assign i_in_chan.ready = !r_valid || i_take;

    // Occupancy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in_chan.ready) begin
            r_valid <= i_in_chan.valid;
        end
    end

    // Payload capture; no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_in_chan.ready && i_in_chan.valid) begin
            r_item.data_byte <= i_in_chan.data_byte;
            r_item.last_byte <= i_in_chan.last_byte;
        end
    end

    assign o_item  = r_item;
    assign o_valid = r_valid;

endmodule

`default_nettype wire

>>> sv/iecr_accum.sv
// Running checksum state and end-of-message status decision of the ICMP echo checker.
`default_nettype none

module iecr_accum (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire iecr_pkg::t_in_item i_item,
    output iecr_pkg::t_result       o_result
);

    logic [15:0] r_full_sum,  n_full_sum;
    logic [15:0] r_reply_sum, n_reply_sum;
    logic [7:0]  r_held_high, n_held_high;
    logic [3:0]  r_byte_pos,  n_byte_pos;
    logic        r_odd,       n_odd;
    logic [7:0]  r_msg_type,  n_msg_type;
    logic [7:0]  r_msg_code,  n_msg_code;

    logic [15:0] word_full;
    logic [15:0] word_reply;
    logic        add_word;
    iecr_pkg::t_status status;

    // Word assembly: a held high byte is completed, or an odd final byte is padded.
    always_comb begin
        word_full  = 16'd0;
        word_reply = 16'd0;
        add_word   = 1'b0;
        if (r_odd) begin
            add_word   = 1'b1;
            word_full  = {r_held_high, i_item.data_byte};
            word_reply = word_full;
            if (r_byte_pos == iecr_pkg::POS_CODE) begin
                // Type byte is replaced by the reply type, which is zero.
                word_reply = {8'd0, i_item.data_byte};
            end
            if (r_byte_pos == iecr_pkg::POS_CSUM_LO) begin
                // The checksum field does not count in the reply sum.
                word_reply = 16'd0;
            end
        end else if (i_item.last_byte) begin
            add_word   = 1'b1;
            word_full  = {i_item.data_byte, 8'd0};
            word_reply = word_full;
            if (r_byte_pos == iecr_pkg::POS_TYPE || r_byte_pos == iecr_pkg::POS_CSUM_HI) begin
                word_reply = 16'd0;
            end
        end
    end

    // Next state of the running sums and header capture.
    always_comb begin
        n_full_sum  = add_word ? iecr_pkg::oc_add(r_full_sum, word_full) : r_full_sum;
        n_reply_sum = add_word ? iecr_pkg::oc_add(r_reply_sum, word_reply) : r_reply_sum;
        n_held_high = r_odd ? r_held_high : (i_item.last_byte ? r_held_high
                                                              : i_item.data_byte);
        n_odd       = !r_odd && !i_item.last_byte;
        n_msg_type  = (r_byte_pos == iecr_pkg::POS_TYPE) ? i_item.data_byte : r_msg_type;
        n_msg_code  = (r_byte_pos == iecr_pkg::POS_CODE) ? i_item.data_byte : r_msg_code;
        n_byte_pos  = (r_byte_pos < iecr_pkg::HEADER_BYTES) ? r_byte_pos + 4'd1 : r_byte_pos;
    end

    // Status priority: short header, bad checksum, unknown type, bad echo code.
    always_comb begin
        if (r_byte_pos < iecr_pkg::HEADER_BYTES - 4'd1) begin
            status = iecr_pkg::ST_SHORT;
        end else if (n_full_sum != iecr_pkg::SUM_GOOD) begin
            status = iecr_pkg::ST_CSUM_ERR;
        end else if (n_msg_type != iecr_pkg::ICMP_TYPE_ECHO_REQ) begin
            status = iecr_pkg::ST_BAD_TYPE;
        end else if (n_msg_code != iecr_pkg::ICMP_CODE_ECHO) begin
            status = iecr_pkg::ST_BAD_CODE;
        end else begin
            status = iecr_pkg::ST_REPLY;
        end
        o_result.status         = status;
        o_result.reply_checksum = (status == iecr_pkg::ST_REPLY) ? ~n_reply_sum : 16'd0;
    end

    // State update; the final byte returns everything to the idle values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.last_byte)) begin
            r_full_sum  <= 16'd0;
            r_reply_sum <= 16'd0;
            r_held_high <= 8'd0;
            r_byte_pos  <= 4'd0;
            r_odd       <= 1'b0;
            r_msg_type  <= 8'd0;
            r_msg_code  <= 8'd0;
        end else if (i_step) begin
            r_full_sum  <= n_full_sum;
            r_reply_sum <= n_reply_sum;
            r_held_high <= n_held_high;
            r_byte_pos  <= n_byte_pos;
            r_odd       <= n_odd;
            r_msg_type  <= n_msg_type;
            r_msg_code  <= n_msg_code;
        end
    end

endmodule

`default_nettype wire
